[rtl/ackfp_pkg.sv]
// Package for the ACK frame parser: beat structs, result kinds, parse phases
// and frame layout constants. No dependencies.
package ackfp_pkg;

  // Frame layout
  localparam int unsigned HEADER_LEN = 10;
  localparam int unsigned PAIR_LEN   = 4;
  localparam int unsigned POS_W      = 11;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_ACK_TYPE_CODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PAIR_LIMIT    = 2'd1;

  typedef enum logic [1:0] {
    KIND_HEADER = 2'd0,
    KIND_PAIR   = 2'd1,
    KIND_END    = 2'd2,
    KIND_ERROR  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    PH_WAIT   = 2'd0,
    PH_HEADER = 2'd1,
    PH_PAIRS  = 2'd2,
    PH_DRAIN  = 2'd3
  } phase_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_buffer;
  } in_beat_t;

  typedef struct packed {
    kind_t       kind;
    logic [31:0] top_acked;
    logic [15:0] ack_delay;
    logic [8:0]  range_total;
    logic [15:0] lead_range;
    logic [7:0]  pair_index;
    logic [15:0] gap_value;
    logic [15:0] range_value;
    logic [10:0] consumed_bytes;
    logic        frame_done;
  } out_beat_t;

endpackage

[rtl/ack_frame_parser_core.sv]
// ACK frame parser top level: byte-wise parse state machine and result register.
// Depends on ackfp_pkg.
//
// Usage: one frame byte per input beat on in_data (data_byte, end_of_buffer).
// The first byte is the type byte, checked against register ack_type_code.
// Each byte gives zero or one result beat on out_data: a header result when
// the first range completes, one result per gap/range pair up to pair_limit,
// an end result when the last pair was skipped, or an error result for a bad
// type byte or a buffer that ends inside a frame. frame_done marks the last
// result of a frame; consumed_bytes then carries the frame length, or zero on an error result.
// A result is registered and valid the cycle after the byte that causes it.
// Throughput: one byte per cycle unless in_ready is low; the parse step is a
// single state update between input handshake and the result register.
// in_ready drops only when the result register is full and out_ready is low,
// so a stalled receiver holds back input with no beat lost.
// Configuration beats on cfg_* are always accepted; write only while idle.
// Reset: parser waits for a type byte, ack_type_code = 0, pair_limit = 255,
// no result pending.
module ack_frame_parser_core (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  ackfp_pkg::in_beat_t                 in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output ackfp_pkg::out_beat_t                out_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [ackfp_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [7:0]                          cfg_data
);

  localparam logic [ackfp_pkg::POS_W-1:0] POS_ONE      = 11'd1;
  localparam logic [ackfp_pkg::POS_W-1:0] POS_LARGEST  = 11'd4;
  localparam logic [ackfp_pkg::POS_W-1:0] POS_DELAY    = 11'd6;
  localparam logic [ackfp_pkg::POS_W-1:0] POS_EXTRA    = 11'd7;
  localparam logic [ackfp_pkg::POS_W-1:0] POS_HDR_LAST = 11'd9;
  localparam logic [ackfp_pkg::POS_W-1:0] HDR_LEN =
    ackfp_pkg::POS_W'(ackfp_pkg::HEADER_LEN);

  // Configuration registers
  logic [7:0] ack_type_code_r;
  logic [7:0] pair_limit_r;

  // Parse state
  ackfp_pkg::phase_t          phase_r, phase_nxt;
  logic [ackfp_pkg::POS_W-1:0] pos_r, pos_nxt;
  logic [31:0]                largest_r, largest_nxt;
  logic [15:0]                delay_r, delay_nxt;
  logic [7:0]                 extra_r, extra_nxt;
  logic [7:0]                 seen_r, seen_nxt;
  logic [15:0]                gap_r, gap_nxt;
  logic [15:0]                shift_r, shift_nxt;

  // Result register
  logic                 out_valid_r;
  ackfp_pkg::out_beat_t out_data_r;

  logic                 in_fire;
  logic                 emit;
  logic                 complete;
  logic                 err;
  logic                 last_pair;
  logic [1:0]           pair_off;
  logic [7:0]           seen_inc;
  ackfp_pkg::out_beat_t res;

  assign in_ready  = !out_valid_r || out_ready;
  assign in_fire   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign cfg_ready = 1'b1;

  // Configuration writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ack_type_code_r <= 8'd0;
      pair_limit_r    <= 8'd255;
    end else if (cfg_valid) begin
      if (cfg_index == ackfp_pkg::CFG_ACK_TYPE_CODE) begin
        ack_type_code_r <= cfg_data;
      end
      if (cfg_index == ackfp_pkg::CFG_PAIR_LIMIT) begin
        pair_limit_r <= cfg_data;
      end
    end
  end

  // Parse step for one byte
  always_comb begin
    phase_nxt   = phase_r;
    pos_nxt     = pos_r;
    largest_nxt = largest_r;
    delay_nxt   = delay_r;
    extra_nxt   = extra_r;
    seen_nxt    = seen_r;
    gap_nxt     = gap_r;
    shift_nxt   = shift_r;
    emit        = 1'b0;
    complete    = 1'b0;
    err         = 1'b0;
    last_pair   = 1'b0;
    res         = '0;
    pair_off    = pos_r[1:0] - 2'd2;
    seen_inc    = seen_r + 8'd1;
    if (in_fire) begin
      unique case (phase_r)
        ackfp_pkg::PH_WAIT: begin
          pos_nxt = '0;
          if (in_data.data_byte != ack_type_code_r) begin
            err       = 1'b1;
            phase_nxt = ackfp_pkg::PH_DRAIN;
          end else begin
            phase_nxt = ackfp_pkg::PH_HEADER;
            pos_nxt   = POS_ONE;
          end
        end
        ackfp_pkg::PH_HEADER: begin
          if (pos_r <= POS_LARGEST) begin
            largest_nxt = {largest_r[23:0], in_data.data_byte};
          end else if (pos_r <= POS_DELAY) begin
            delay_nxt = {delay_r[7:0], in_data.data_byte};
          end else if (pos_r == POS_EXTRA) begin
            extra_nxt = in_data.data_byte;
          end else begin
            shift_nxt = {shift_r[7:0], in_data.data_byte};
          end
          // header complete with the first range
          if (pos_r >= POS_HDR_LAST) begin
            emit              = 1'b1;
            res.kind          = ackfp_pkg::KIND_HEADER;
            res.top_acked     = largest_r;
            res.ack_delay     = delay_r;
            res.range_total   = {1'b0, extra_r} + 9'd1;
            res.lead_range    = shift_nxt;
            if (extra_r == 8'd0) begin
              complete  = 1'b1;
              phase_nxt = ackfp_pkg::PH_DRAIN;
            end else begin
              seen_nxt  = '0;
              phase_nxt = ackfp_pkg::PH_PAIRS;
            end
          end
          pos_nxt = pos_r + POS_ONE;
        end
        ackfp_pkg::PH_PAIRS: begin
          if (!pair_off[1]) begin
            gap_nxt = {gap_r[7:0], in_data.data_byte};
          end else begin
            shift_nxt = {shift_r[7:0], in_data.data_byte};
          end
          // last byte of a pair
          if (pair_off == 2'd3) begin
            seen_nxt  = seen_inc;
            last_pair = (seen_inc == extra_r);
            if (seen_r < pair_limit_r) begin
              emit            = 1'b1;
              res.kind        = ackfp_pkg::KIND_PAIR;
              res.pair_index  = seen_r;
              res.gap_value   = gap_r;
              res.range_value = shift_nxt;
            end else if (last_pair) begin
              emit     = 1'b1;
              res.kind = ackfp_pkg::KIND_END;
            end
            if (last_pair) begin
              complete  = 1'b1;
              phase_nxt = ackfp_pkg::PH_DRAIN;
            end
          end
          pos_nxt = pos_r + POS_ONE;
        end
        ackfp_pkg::PH_DRAIN: begin
        end
        default: begin
        end
      endcase

      // buffer ended inside a frame
      if (in_data.end_of_buffer &&
          (phase_nxt == ackfp_pkg::PH_HEADER || phase_nxt == ackfp_pkg::PH_PAIRS)) begin
        err = 1'b1;
      end

      if (err) begin
        res            = '0;
        res.kind       = ackfp_pkg::KIND_ERROR;
        res.frame_done = 1'b1;
        emit           = 1'b1;
      end else if (complete) begin
        res.consumed_bytes = HDR_LEN + {1'b0, extra_r, 2'b00};
        res.frame_done     = 1'b1;
      end

      if (in_data.end_of_buffer) begin
        phase_nxt = ackfp_pkg::PH_WAIT;
        pos_nxt   = '0;
      end
    end
  end

  // Parse state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= ackfp_pkg::PH_WAIT;
      pos_r     <= '0;
      largest_r <= '0;
      delay_r   <= '0;
      extra_r   <= '0;
      seen_r    <= '0;
      gap_r     <= '0;
      shift_r   <= '0;
    end else begin
      phase_r   <= phase_nxt;
      pos_r     <= pos_nxt;
      largest_r <= largest_nxt;
      delay_r   <= delay_nxt;
      extra_r   <= extra_nxt;
      seen_r    <= seen_nxt;
      gap_r     <= gap_nxt;
      shift_r   <= shift_nxt;
    end
  end

  // Result register: loads on an emitting byte, drains on out_ready
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire && emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && emit) begin
      out_data_r <= res;
    end
  end

endmodule

[test/ack_frame_parser_core_test.sv]
// Testbench for ack_frame_parser_core: streams byte buffers of well-formed,
// truncated, mistyped and noise frames; a byte-wise parse model predicts each result.
// Depends on ackfp_pkg and the ack_frame_parser_core RTL.
module ack_frame_parser_core_test;

  typedef logic [7:0] byte_q_t[$];

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            in_valid = 1'b0;
  logic                            in_ready;
  ackfp_pkg::in_beat_t             in_data = '0;
  logic                            out_valid;
  logic                            out_ready = 1'b0;
  ackfp_pkg::out_beat_t            out_data;
  logic                            cfg_valid = 1'b0;
  logic                            cfg_ready;
  logic [ackfp_pkg::CFG_IDX_W-1:0] cfg_index = ackfp_pkg::CFG_ACK_TYPE_CODE;
  logic [7:0]                      cfg_data = '0;

  ack_frame_parser_core DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Run limit, far above the slowest legal run
  initial begin
    #5000000;
    $display("simulation failed");
    $finish;
  end

  // Bytes waiting for the driver, and bookkeeping shared by the processes
  ackfp_pkg::in_beat_t  byte_stream[$];
  ackfp_pkg::out_beat_t frame_results_due[$];
  int        beats_queued = 0;
  int        bytes_accepted = 0;
  int        results_seen = 0;
  int        mismatches = 0;
  bit        in_taken = 1'b0;
  bit        quiet_tail = 1'b0;

  // Parser model state and its copy of the registers
  logic [7:0]        type_code_reg;
  logic [7:0]        pair_limit_reg;
  ackfp_pkg::phase_t phase;
  logic [10:0]       pos;
  logic [31:0]       largest_hold;
  logic [15:0]       delay_hold;
  logic [15:0]       gap_hold;
  logic [15:0]       field_shift;
  logic [7:0]        extra_pairs;
  logic [7:0]        pairs_seen;

  function automatic void clear_frame();
    pos = '0;
    largest_hold = '0;
    delay_hold = '0;
    extra_pairs = '0;
    pairs_seen = '0;
    gap_hold = '0;
    field_shift = '0;
  endfunction

  function automatic void reset_parser_model();
    type_code_reg = 8'd0;
    pair_limit_reg = 8'd255;
    phase = ackfp_pkg::PH_WAIT;
    clear_frame();
  endfunction

  // Advance the parse model by one byte; queue the result it gives, if any
  function automatic void parse_byte(ackfp_pkg::in_beat_t beat);
    ackfp_pkg::out_beat_t r;
    bit          emit;
    bit          complete;
    bit          err;
    bit          last_pair;
    logic [10:0] rel;
    logic [7:0]  idx;
    r = '0;
    emit = 1'b0;
    complete = 1'b0;
    err = 1'b0;
    case (phase)
      ackfp_pkg::PH_WAIT: begin
        clear_frame();
        if (beat.data_byte != type_code_reg) begin
          err = 1'b1;
          phase = ackfp_pkg::PH_DRAIN;
        end else begin
          phase = ackfp_pkg::PH_HEADER;
          pos = 11'd1;
        end
      end
      ackfp_pkg::PH_HEADER: begin
        if (pos <= 11'd4) largest_hold = {largest_hold[23:0], beat.data_byte};
        else if (pos <= 11'd6) delay_hold = {delay_hold[7:0], beat.data_byte};
        else if (pos == 11'd7) extra_pairs = beat.data_byte;
        else field_shift = {field_shift[7:0], beat.data_byte};
        if (pos >= 11'd9) begin
          emit = 1'b1;
          r.kind = ackfp_pkg::KIND_HEADER;
          r.top_acked = largest_hold;
          r.ack_delay = delay_hold;
          r.range_total = 9'(extra_pairs) + 9'd1;
          r.lead_range = field_shift;
          if (extra_pairs == 8'd0) begin
            complete = 1'b1;
            phase = ackfp_pkg::PH_DRAIN;
          end else begin
            pairs_seen = '0;
            phase = ackfp_pkg::PH_PAIRS;
          end
        end
        pos = pos + 11'd1;
      end
      ackfp_pkg::PH_PAIRS: begin
        rel = pos - 11'(ackfp_pkg::HEADER_LEN);
        if (rel[1:0] < 2'd2) gap_hold = {gap_hold[7:0], beat.data_byte};
        else field_shift = {field_shift[7:0], beat.data_byte};
        if (rel[1:0] == 2'd3) begin
          idx = pairs_seen;
          pairs_seen = pairs_seen + 8'd1;
          last_pair = (pairs_seen == extra_pairs);
          if (idx < pair_limit_reg) begin
            emit = 1'b1;
            r.kind = ackfp_pkg::KIND_PAIR;
            r.pair_index = idx;
            r.gap_value = gap_hold;
            r.range_value = field_shift;
          end else if (last_pair) begin
            emit = 1'b1;
            r.kind = ackfp_pkg::KIND_END;
          end
          if (last_pair) begin
            complete = 1'b1;
            phase = ackfp_pkg::PH_DRAIN;
          end
        end
        pos = pos + 11'd1;
      end
      default: ;
    endcase

    // Buffer ending inside a frame overrides anything else
    if ((phase == ackfp_pkg::PH_HEADER || phase == ackfp_pkg::PH_PAIRS) &&
        beat.end_of_buffer) err = 1'b1;

    if (err) begin
      r = '0;
      r.kind = ackfp_pkg::KIND_ERROR;
      r.frame_done = 1'b1;
      emit = 1'b1;
    end else if (complete) begin
      r.consumed_bytes = 11'(ackfp_pkg::HEADER_LEN + ackfp_pkg::PAIR_LEN * extra_pairs);
      r.frame_done = 1'b1;
    end

    if (beat.end_of_buffer) begin
      phase = ackfp_pkg::PH_WAIT;
      pos = '0;
    end
    if (emit) frame_results_due.push_back(r);
  endfunction

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want, inout bit bad);
    if (got !== want) begin
      if (mismatches < 10)
        $display("%0t result %0d %s: expected 0x%0h, got 0x%0h",
                 $time, results_seen, name, want, got);
      bad = 1'b1;
    end
  endtask

  task automatic check_result(input ackfp_pkg::out_beat_t got);
    ackfp_pkg::out_beat_t want;
    bit        bad;
    bad = 1'b0;
    if (frame_results_due.size() == 0) begin
      if (mismatches < 10)
        $display("%0t result %0d: unexpected beat, kind %0d", $time, results_seen, got.kind);
      mismatches++;
    end else begin
      want = frame_results_due.pop_front();
      check_field("kind", 32'(got.kind), 32'(want.kind), bad);
      check_field("top_acked", got.top_acked, want.top_acked, bad);
      check_field("ack_delay", 32'(got.ack_delay), 32'(want.ack_delay), bad);
      check_field("range_total", 32'(got.range_total), 32'(want.range_total), bad);
      check_field("lead_range", 32'(got.lead_range), 32'(want.lead_range), bad);
      check_field("pair_index", 32'(got.pair_index), 32'(want.pair_index), bad);
      check_field("gap_value", 32'(got.gap_value), 32'(want.gap_value), bad);
      check_field("range_value", 32'(got.range_value), 32'(want.range_value), bad);
      check_field("consumed_bytes", 32'(got.consumed_bytes), 32'(want.consumed_bytes), bad);
      check_field("frame_done", 32'(got.frame_done), 32'(want.frame_done), bad);
      if (bad) mismatches++;
    end
    results_seen++;
  endtask

  // Monitor: register writes, accepted bytes and result beats at the rising edge
  always @(posedge clk) begin
    if (!rst_n) begin
      in_taken = 1'b0;
      reset_parser_model();
    end else begin
      in_taken = in_valid && in_ready;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          ackfp_pkg::CFG_ACK_TYPE_CODE: type_code_reg = cfg_data;
          ackfp_pkg::CFG_PAIR_LIMIT:    pair_limit_reg = cfg_data;
          default: ;
        endcase
      end
      if (in_taken) begin
        parse_byte(in_data);
        bytes_accepted++;
      end
      if (out_valid && out_ready) check_result(out_data);
    end
  end

  // Byte driver: holds each beat until taken, idles in random bursts
  int src_gap = 0;
  always @(negedge clk) begin
    if (rst_n && !(in_valid && !in_taken)) begin
      if (src_gap > 0) begin
        src_gap--;
        in_valid <= 1'b0;
      end else if (!quiet_tail && $urandom_range(0, 7) == 0) begin
        src_gap = $urandom_range(1, 19) - 1;
        in_valid <= 1'b0;
      end else if (byte_stream.size() != 0) begin
        in_data <= byte_stream.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result sink: random stall bursts plus one long hold-off to back up the input
  int  sink_gap = 0;
  int  long_hold_left = 0;
  bit  long_hold_done = 1'b0;
  always @(negedge clk) begin
    if (long_hold_left > 0) begin
      long_hold_left--;
      out_ready <= 1'b0;
    end else if (!long_hold_done && bytes_accepted >= 120) begin
      long_hold_done = 1'b1;
      long_hold_left = 299;
      out_ready <= 1'b0;
    end else if (sink_gap > 0) begin
      sink_gap--;
      out_ready <= 1'b0;
    end else if (!quiet_tail && $urandom_range(0, 7) == 0) begin
      sink_gap = $urandom_range(1, 19) - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Field values leaning toward the extremes
  function automatic logic [31:0] pick32();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [15:0] pick16();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic byte_q_t build_frame(input logic [7:0] type_byte,
                                          input logic [31:0] largest,
                                          input logic [15:0] delay,
                                          input logic [7:0] extra,
                                          input logic [15:0] first);
    byte_q_t     q;
    logic [15:0] gap;
    logic [15:0] len;
    q = '{type_byte, largest[31:24], largest[23:16], largest[15:8], largest[7:0],
          delay[15:8], delay[7:0], extra, first[15:8], first[7:0]};
    for (int i = 0; i < extra; i++) begin
      gap = pick16();
      len = pick16();
      q.push_back(gap[15:8]);
      q.push_back(gap[7:0]);
      q.push_back(len[15:8]);
      q.push_back(len[7:0]);
    end
    return q;
  endfunction

  // One buffer: end_of_buffer marks its last byte
  task automatic send_buffer(input byte_q_t q);
    ackfp_pkg::in_beat_t beat;
    foreach (q[i]) begin
      beat.data_byte = q[i];
      beat.end_of_buffer = (i == q.size() - 1);
      byte_stream.push_back(beat);
    end
    beats_queued += q.size();
  endtask

  // Mostly well-formed frames, some truncated, mistyped or pure noise
  task automatic random_buffer(input logic [7:0] code, input int max_extra);
    byte_q_t q;
    int      sel;
    int      junk;
    sel = $urandom_range(0, 19);
    q = build_frame(code, pick32(), pick16(), 8'($urandom_range(0, max_extra)), pick16());
    if (sel < 14) begin
      junk = $urandom_range(0, 1) ? 0 : $urandom_range(1, 3);
      repeat (junk) q.push_back(8'($urandom));
    end else if (sel < 17) begin
      junk = $urandom_range(1, q.size() - 1);
      while (q.size() > junk) void'(q.pop_back());
    end else if (sel < 19) begin
      q.delete();
      q.push_back(code ^ 8'($urandom_range(1, 255)));
      repeat ($urandom_range(0, 3)) q.push_back(8'($urandom));
    end else begin
      q.delete();
      repeat ($urandom_range(1, 5)) q.push_back(8'($urandom));
    end
    send_buffer(q);
  endtask

  task automatic random_phase(input logic [7:0] code, input int max_extra, input int count);
    int target;
    target = beats_queued + count;
    while (beats_queued < target) random_buffer(code, max_extra);
  endtask

  // Idle: every byte taken, every result back, then slack before returning
  task automatic wait_idle();
    do @(negedge clk);
    while (bytes_accepted != beats_queued || frame_results_due.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [ackfp_pkg::CFG_IDX_W-1:0] idx,
                           input logic [7:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
  endtask

  task automatic write_config(input logic [7:0] type_byte, input logic [7:0] limit);
    write_reg(ackfp_pkg::CFG_ACK_TYPE_CODE, type_byte);
    write_reg(ackfp_pkg::CFG_PAIR_LIMIT, limit);
    cfg_valid <= 1'b0;
  endtask

  // Stimulus
  initial begin
    byte_q_t q;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    write_config(8'h02, 8'd255);
    // wrong type byte alone, then wrong type followed by an ignored byte
    q = '{8'h5a};
    send_buffer(q);
    q = '{8'hfd, 8'h02};
    send_buffer(q);
    // all-ones header with no extra pairs
    send_buffer(build_frame(8'h02, '1, '1, 8'd0, '1));
    // buffer ends inside the largest-acked field
    q = build_frame(8'h02, '0, '0, 8'd0, '0);
    while (q.size() > 4) void'(q.pop_back());
    send_buffer(q);
    // buffer ends on the byte that completes the header while pairs are due
    q = build_frame(8'h02, 32'h1234_5678, 16'h9abc, 8'd1, 16'hdef0);
    while (q.size() > 10) void'(q.pop_back());
    send_buffer(q);

    random_phase(8'h02, 6, 150);
    // long frame: 80 pairs, all reported
    send_buffer(build_frame(8'h02, pick32(), pick16(), 8'd80, pick16()));

    wait_idle();
    write_config(8'hff, 8'd0);
    random_phase(8'hff, 6, 100);

    wait_idle();
    write_config(8'h00, 8'd2);
    random_phase(8'h00, 6, 150);

    wait_idle();
    write_config(8'($urandom), 8'($urandom_range(1, 4)));
    quiet_tail <= 1'b1;
    random_phase(type_code_reg, 8, 100);

    wait_idle();
    repeat (10) @(negedge clk);
    if (mismatches == 0 && frame_results_due.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/ackfp_pkg.sv
rtl/ack_frame_parser_core.sv
test/ack_frame_parser_core_test.sv
